[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define TMWF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tmwf assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define TMWF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tmwf assertion failed");

`endif

[rtl/tmwf_pkg.sv]
package tmwf_pkg;

   localparam int WINDOW_DEF    = 14;
   localparam int CHANNELS_DEF  = 11;
   localparam int TRIM_LOW_DEF  = 2;
   localparam int TRIM_HIGH_DEF = 3;

   localparam int CH_W     = 4;
   localparam int SAMPLE_W = 12;
   localparam int FS_W     = 12;
   localparam int RESULT_W = 16;

   localparam int FULL_CODE = 4095;
   localparam logic [FS_W-1:0] FS_RESET = 12'd3000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_RANK,
      ST_MUL,
      ST_DIV_START,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

[rtl/tmwf_ram.sv]
module tmwf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 154,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tmwf_divider.sv]
module tmwf_divider #(
   parameter int NUM_W = 33,
   parameter int DEN   = 45045
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int DenW  = $clog2(DEN + 1);
   localparam int Shift = NUM_W + DenW;
   localparam int RecW  = NUM_W + 2;
   localparam int HalfW = (RecW + 1) / 2;
   localparam int PartW = NUM_W + HalfW;
   localparam int AccW  = NUM_W + RecW;
   localparam longint unsigned Recip =
      ((64'd1 << Shift) + 64'(DEN) - 64'd1) / 64'(DEN);
   localparam logic [RecW-1:0]  RecipBits = RecW'(Recip);
   localparam logic [HalfW-1:0] RecipLo   = RecipBits[HalfW-1:0];
   localparam logic [HalfW-1:0] RecipHi   = HalfW'(RecipBits >> HalfW);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [AccW-1:0]  acc_ff, acc_in;
   logic             busy_ff, busy_in;
   logic             hi_ff, hi_in;
   logic             done_ff, done_in;
   logic [HalfW-1:0] mul_b;
   logic [PartW-1:0] part;

   // reciprocal product in two halves on one multiplier
   always_comb begin
      mul_b   = hi_ff ? RecipHi : RecipLo;
      part    = PartW'(num_ff) * PartW'(mul_b);
      num_in  = num_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      hi_in   = hi_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         acc_in  = '0;
         busy_in = 1'b1;
         hi_in   = 1'b0;
      end else if (busy_ff) begin
         if (hi_ff) begin
            acc_in  = acc_ff + (AccW'(part) << HalfW);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = acc_ff + AccW'(part);
         end
         hi_in = !hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         hi_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         hi_ff   <= hi_in;
      end
      num_ff <= num_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign quotient = NUM_W'(acc_ff >> Shift);

endmodule

[rtl/trimmed_mean_window_filter_top.sv]
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_channel, req_sample
// rsp      out        rsp_valid/rsp_stall   rsp_channel_out, rsp_filtered_mv_q4
// csr      in         csr_wr_en             csr_wr_data (full scale in mV)
//
// one word at a time; the time from accept to result is set by the window
// read and the rank walk, entry by entry, and the two-step reciprocal divide.
// an out-of-range channel skips these steps and answers with zero.
// windows read as zero after reset through per-entry valid bits.
// req_stall is high from accept until the result word is taken.
module trimmed_mean_window_filter_top import tmwf_pkg::*; #(
   parameter int WINDOW    = WINDOW_DEF,
   parameter int CHANNELS  = CHANNELS_DEF,
   parameter int TRIM_LOW  = TRIM_LOW_DEF,
   parameter int TRIM_HIGH = TRIM_HIGH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CH_W-1:0]     req_channel,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CH_W-1:0]     rsp_channel_out,
   output logic [RESULT_W-1:0] rsp_filtered_mv_q4,
   input  logic                csr_wr_en,
   input  logic [FS_W-1:0]     csr_wr_data
);

   localparam int Depth   = CHANNELS * WINDOW;
   localparam int AddrW   = $clog2(Depth);
   localparam int IdxW    = $clog2(WINDOW);
   localparam int CntW    = IdxW + 1;
   localparam int ChIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int Kept    = WINDOW - TRIM_LOW - TRIM_HIGH;
   localparam int KeepHi  = WINDOW - TRIM_HIGH;
   localparam int Den     = (Kept > 0) ? FULL_CODE * Kept : 1;
   localparam int HalfDen = Den / 2;
   localparam int SumW    = $clog2(WINDOW * FULL_CODE + 1);
   localparam int ProdW   = SumW + FS_W;
   localparam int NumW    = ProdW + 4 + 1;

   state_type             state_ff, state_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic [CH_W-1:0]       ch_ff, ch_in;
   logic [SAMPLE_W-1:0]   smp_ff, smp_in;
   logic [AddrW-1:0]      base_ff, base_in;
   logic [FS_W-1:0]       fs_ff, fs_in;
   logic [SumW-1:0]       sum_ff, sum_in;
   logic [ProdW-1:0]      prod_ff, prod_in;
   logic [RESULT_W-1:0]   res_ff, res_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SAMPLE_W-1:0]   win_ff [WINDOW];
   logic [SAMPLE_W-1:0]   win_in [WINDOW];
   logic [IdxW-1:0]       head_ff [CHANNELS];
   logic [IdxW-1:0]       head_in [CHANNELS];
   logic [Depth-1:0]      valid_ff, valid_in;

   logic                  ram_we;
   logic [AddrW-1:0]      ram_wr_addr;
   logic [AddrW-1:0]      ram_rd_addr;
   logic [SAMPLE_W-1:0]   ram_rd_data;
   logic [IdxW-1:0]       rd_idx;
   logic [ChIW-1:0]       chi;
   logic                  div_start;
   logic [NumW-1:0]       div_dividend;
   logic                  div_done;
   logic [NumW-1:0]       div_quot;
   logic [SAMPLE_W-1:0]   rank_x;
   logic [WINDOW-1:0]     less;
   logic [CntW-1:0]       rank;
   logic                  keep;

   tmwf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (Depth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (smp_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tmwf_divider #(
      .NUM_W (NumW),
      .DEN   (Den)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quot)
   );

   // rank of the selected entry, ties broken by slot
   always_comb begin
      rank_x = win_ff[cnt_ff[IdxW-1:0]];
      for (int j = 0; j < WINDOW; j++) begin
         less[j] = (win_ff[j] < rank_x) ||
                   ((win_ff[j] == rank_x) && (CntW'(j) < cnt_ff));
      end
      rank = CntW'($countones(less));
      keep = (int'(rank) >= TRIM_LOW) && (int'(rank) < KeepHi);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      smp_in       = smp_ff;
      base_in      = base_ff;
      fs_in        = csr_wr_en ? csr_wr_data : fs_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      win_in       = win_ff;
      head_in      = head_ff;
      valid_in     = valid_ff;
      chi          = ch_ff[ChIW-1:0];
      rd_idx       = (cnt_ff < CntW'(WINDOW)) ? cnt_ff[IdxW-1:0] : '0;
      ram_rd_addr  = base_ff + AddrW'(rd_idx);
      ram_wr_addr  = base_ff + AddrW'(head_ff[chi]);
      rd_vld_in    = valid_ff[ram_rd_addr];
      ram_we       = 1'b0;
      div_start    = 1'b0;
      div_dividend = NumW'({prod_ff, 4'h0}) + NumW'(HalfDen);
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ch_in   = req_channel;
               smp_in  = req_sample;
               base_in = AddrW'(req_channel) * AddrW'(WINDOW);
               if (int'(req_channel) >= CHANNELS) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            // new sample replaces the oldest slot
            ram_we                = 1'b1;
            valid_in[ram_wr_addr] = 1'b1;
            head_in[chi] = (head_ff[chi] == IdxW'(WINDOW - 1)) ? '0 : head_ff[chi] + 1'b1;
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (cnt_ff != '0) begin
               win_in[cnt_ff[IdxW-1:0] - 1'b1] = rd_vld_ff ? ram_rd_data : '0;
            end
            if (cnt_ff == CntW'(WINDOW)) begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_RANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RANK: begin
            if (keep) begin
               sum_in = sum_ff + SumW'(rank_x);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(WINDOW - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = ProdW'(sum_ff) * ProdW'(fs_ff);
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = RESULT_W'(div_quot);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fs_ff    <= FS_RESET;
         valid_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            head_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fs_ff    <= fs_in;
         valid_ff <= valid_in;
         head_ff  <= head_in;
      end
      ch_ff     <= ch_in;
      smp_ff    <= smp_in;
      base_ff   <= base_in;
      sum_ff    <= sum_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      rd_vld_ff <= rd_vld_in;
      win_ff    <= win_in;
   end

   assign rsp_channel_out    = ch_ff;
   assign rsp_filtered_mv_q4 = res_ff;

endmodule

[rtl/tmwf_checker.sv]
`include "assert_macros.svh"

module tmwf_checker import tmwf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [RESULT_W-1:0] rsp_filtered_mv_q4
);

   // a held result word stays offered
   `TMWF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // one word in flight: busy right after accept
   `TMWF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // no new word while a result waits
   `TMWF_ASSERT_IMP(a_stall_with_rsp, rsp_valid, req_stall)

   // result never exceeds full scale of 4095 mv
   `TMWF_ASSERT_IMP(a_rsp_range, rsp_valid, rsp_filtered_mv_q4 <= 16'd65520)

endmodule

bind trimmed_mean_window_filter_top tmwf_checker u_tmwf_checker (.*);

[tb/trimmed_mean_window_filter_top_tb.sv]
module trimmed_mean_window_filter_top_tb import tmwf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = WINDOW_DEF;
   localparam int NCH = CHANNELS_DEF;
   localparam int TLO = TRIM_LOW_DEF;
   localparam int THI = TRIM_HIGH_DEF;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [SAMPLE_W-1:0] sample;
   } sample_word_type;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [RESULT_W-1:0] mv_q4;
   } filtered_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [CH_W-1:0] req_channel = '0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [CH_W-1:0] rsp_channel_out;
   logic [RESULT_W-1:0] rsp_filtered_mv_q4;
   logic csr_wr_en = 0;
   logic [FS_W-1:0] csr_wr_data = '0;

   sample_word_type pending_words[$];
   filtered_word_type expected_words[$];
   logic [SAMPLE_W-1:0] windows[NCH][WIN];
   logic [FS_W-1:0] full_scale;
   int send_idle_pct = 31;
   int recv_idle_pct = 53;
   int errors = 0;
   int cycles = 0;

   trimmed_mean_window_filter_top dut (.*);

   always #5 clock = ~clock;

   function automatic filtered_word_type filter_sample(sample_word_type w);
      filtered_word_type r;
      logic [SAMPLE_W-1:0] sorted[WIN];
      logic [SAMPLE_W-1:0] x;
      longint unsigned sum, num, den;
      int kept;
      r.channel = w.channel;
      r.mv_q4 = '0;
      if (w.channel >= NCH) return r;
      for (int i = WIN - 1; i > 0; i--) windows[w.channel][i] = windows[w.channel][i-1];
      windows[w.channel][0] = w.sample;
      kept = WIN - TLO - THI;
      if (kept <= 0) return r;
      sorted = windows[w.channel];
      for (int i = 1; i < WIN; i++) begin
         for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
            x = sorted[j];
            sorted[j] = sorted[j-1];
            sorted[j-1] = x;
         end
      end
      sum = 0;
      for (int i = TLO; i < WIN - THI; i++) sum += sorted[i];
      num = sum * full_scale * 16;
      den = FULL_CODE * kept;
      r.mv_q4 = RESULT_W'((num + den / 2) / den);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("trimmed_mean_window_filter_top_tb failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               sample_word_type w;
               w = pending_words.pop_front();
               expected_words.push_back(filter_sample(w));
               req_channel <= w.channel;
               req_sample <= w.sample;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word channel %0d value %0d", rsp_channel_out,
                   rsp_filtered_mv_q4);
            errors++;
         end else begin
            filtered_word_type e;
            e = expected_words.pop_front();
            if (rsp_channel_out !== e.channel) begin
               $error("channel_out expected %0d actual %0d", e.channel, rsp_channel_out);
               errors++;
            end
            if (rsp_filtered_mv_q4 !== e.mv_q4) begin
               $error("filtered_mv_q4 expected %0d actual %0d", e.mv_q4,
                      rsp_filtered_mv_q4);
               errors++;
            end
         end
      end
   end

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_full_scale(logic [FS_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      full_scale = v;
   endtask

   task automatic add_random(int n);
      sample_word_type w;
      int mode;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(9);
         w.channel = (mode == 0) ? CH_W'($urandom_range(15, NCH)) :
                                   CH_W'($urandom_range(NCH - 1));
         case ($urandom_range(3))
            0: w.sample = SAMPLE_W'($urandom);
            1: w.sample = SAMPLE_W'($urandom_range(4095, 4000));
            2: w.sample = SAMPLE_W'($urandom_range(100));
            default: w.sample = SAMPLE_W'($urandom_range(2200, 1800));
         endcase
         pending_words.push_back(w);
      end
   endtask

   initial begin
      sample_word_type w;
      logic [FS_W-1:0] scales[6];
      scales = '{12'd4095, 12'd1, 12'd0, 12'd2500, 12'd3300, 12'd4095};
      full_scale = FS_RESET;
      foreach (windows[c, i]) windows[c][i] = '0;
      repeat (9) @(posedge clock);
      reset <= 0;
      // directed: extremes, all channels, out-of-range channels
      for (int i = 0; i < 16; i++) begin
         w.channel = CH_W'(i);
         w.sample = (i % 2) ? 12'hFFF : 12'h000;
         pending_words.push_back(w);
      end
      for (int i = 0; i < WIN - 5; i++) begin
         w.channel = 0;
         w.sample = 12'hFFF;
         pending_words.push_back(w);
      end
      drain();
      foreach (scales[k]) begin
         if (k == 0) begin
            send_idle_pct = 31;
            recv_idle_pct = 53;
         end else if (k == 2) begin
            send_idle_pct = 53;
            recv_idle_pct = 31;
         end else if (k == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_full_scale(scales[k]);
         add_random(180);
         drain();
      end
      if (errors == 0) begin
         $display("trimmed_mean_window_filter_top_tb passed");
      end else begin
         $display("trimmed_mean_window_filter_top_tb failed");
      end
      $finish;
   end
endmodule
